@@ design/rhc_pkg.sv @@
`default_nettype none

package rhc_pkg;

    // channel width of the pixel stream
    localparam int CHANNEL_BITS = 8;

    // hue and saturation are 16-bit fractions
    localparam int FRAC_BITS = 16;

    // long division split over this many register stages
    localparam int DIV_STAGES = 4;
    localparam int BITS_PER_STAGE = FRAC_BITS / DIV_STAGES;

    // 6*spread fits in CHANNEL_BITS+3 bits
    localparam int HUE_DEN_W = CHANNEL_BITS + 3;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [FRAC_BITS-1:0]    hue;
        logic [FRAC_BITS-1:0]    saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_hsv;

    // partial state of both divisions as it travels down the pipe
    typedef struct packed {
        logic [HUE_DEN_W-1:0]    hue_rem;
        logic [HUE_DEN_W-1:0]    hue_den;
        logic [FRAC_BITS-1:0]    hue_q;
        logic [CHANNEL_BITS-1:0] sat_rem;
        logic [CHANNEL_BITS-1:0] sat_den;
        logic [FRAC_BITS-1:0]    sat_q;
        logic                    sat_full;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_div_work;

endpackage

`default_nettype wire

@@ design/rhc_div_stage.sv @@
`default_nettype none

module rhc_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rhc_pkg::t_div_work i_work,
    output logic              o_valid,
    input  logic              i_ready,
    output rhc_pkg::t_div_work o_work
);
    import rhc_pkg::*;

    logic      r_valid;
    t_div_work r_work;
    t_div_work n_work;

    // BITS_PER_STAGE restoring division steps for hue and saturation side by side
    always_comb begin
        logic [HUE_DEN_W:0]    hue_r2;
        logic [CHANNEL_BITS:0] sat_r2;
        n_work = i_work;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            hue_r2 = {n_work.hue_rem, 1'b0};
            if (hue_r2 >= {1'b0, n_work.hue_den}) begin
                hue_r2 = hue_r2 - {1'b0, n_work.hue_den};
                n_work.hue_q = {n_work.hue_q[FRAC_BITS-2:0], 1'b1};
            end else begin
                n_work.hue_q = {n_work.hue_q[FRAC_BITS-2:0], 1'b0};
            end
            n_work.hue_rem = hue_r2[HUE_DEN_W-1:0];

            sat_r2 = {n_work.sat_rem, 1'b0};
            if (sat_r2 >= {1'b0, n_work.sat_den}) begin
                sat_r2 = sat_r2 - {1'b0, n_work.sat_den};
                n_work.sat_q = {n_work.sat_q[FRAC_BITS-2:0], 1'b1};
            end else begin
                n_work.sat_q = {n_work.sat_q[FRAC_BITS-2:0], 1'b0};
            end
            n_work.sat_rem = sat_r2[CHANNEL_BITS-1:0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

`default_nettype wire

@@ design/rgb_to_hsv_converter_core.sv @@
`default_nettype none

// rgb to hsv pixel converter: takes one pixel of three unsigned 8-bit channels per request
// and returns hue and saturation as 16-bit fractions plus brightness (the largest channel).
// the pipe accepts one pixel every clock while its output is not stalled. its stages are
// one stage for max/min and sector, one for the hue numerator and divisor,
// then four stages of the 16-step long division (four quotient bits per stage, hue and
// saturation divided side by side). every stage has its own valid bit and a stage loads
// whenever it is empty or its successor moves, so bubbles collapse and a stalled output
// holds its request without losing anything. black pixels give hue and saturation 0, grey
// pixels give hue 0, and a non-black pixel with a zero channel gives saturation 65535.

module rgb_to_hsv_converter_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rhc_pkg::t_pixel i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rhc_pkg::t_hsv   o_out_req
);
    import rhc_pkg::*;

    // signed numerator width: covers 6*spread and negative channel differences
    localparam int NUM_W = CHANNEL_BITS + 4;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // ---------------- stage 1: max, min, sector ----------------
    logic                    r_s1_valid;
    logic [CHANNEL_BITS-1:0] r_s1_hi;
    logic [CHANNEL_BITS-1:0] r_s1_spread;
    t_sector                 r_s1_sector;
    logic [CHANNEL_BITS:0]   r_s1_diff;

    logic [CHANNEL_BITS-1:0] n_s1_hi;
    logic [CHANNEL_BITS-1:0] n_s1_lo;
    t_sector                 n_s1_sector;
    logic [CHANNEL_BITS:0]   n_s1_diff;
    logic                    s1_ready;

    always_comb begin
        n_s1_hi = i_in_req.red;
        n_s1_lo = i_in_req.red;
        if (i_in_req.green > n_s1_hi) n_s1_hi = i_in_req.green;
        if (i_in_req.blue  > n_s1_hi) n_s1_hi = i_in_req.blue;
        if (i_in_req.green < n_s1_lo) n_s1_lo = i_in_req.green;
        if (i_in_req.blue  < n_s1_lo) n_s1_lo = i_in_req.blue;

        // ties go to red first, then green
        if (i_in_req.red == n_s1_hi) begin
            n_s1_sector = SEC_RED;
            n_s1_diff   = {1'b0, i_in_req.green} - {1'b0, i_in_req.blue};
        end else if (i_in_req.green == n_s1_hi) begin
            n_s1_sector = SEC_GREEN;
            n_s1_diff   = {1'b0, i_in_req.blue} - {1'b0, i_in_req.red};
        end else begin
            n_s1_sector = SEC_BLUE;
            n_s1_diff   = {1'b0, i_in_req.red} - {1'b0, i_in_req.green};
        end
    end

    assign o_in_ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_hi     <= n_s1_hi;
            r_s1_spread <= n_s1_hi - n_s1_lo;
            r_s1_sector <= n_s1_sector;
            r_s1_diff   <= n_s1_diff;
        end
    end

    // ---------------- stage 2: hue numerator, divisors ----------------
    logic      r_s2_valid;
    t_div_work r_s2_work;
    t_div_work n_s2_work;
    logic      s2_ready;

    logic [NUM_W-1:0] spread_x;
    logic [NUM_W-1:0] six_spread;
    logic [NUM_W-1:0] sector_base;
    logic [NUM_W-1:0] hue_num;

    always_comb begin
        spread_x   = {4'b0, r_s1_spread};
        six_spread = (spread_x << 2) + (spread_x << 1);
        case (r_s1_sector)
            SEC_GREEN: sector_base = spread_x << 1;
            SEC_BLUE:  sector_base = spread_x << 2;
            default:   sector_base = '0;
        endcase
        hue_num = sector_base + {{3{r_s1_diff[CHANNEL_BITS]}}, r_s1_diff};
        // wrap a negative numerator into the last sixth of the turn
        if (hue_num[NUM_W-1]) begin
            hue_num = hue_num + six_spread;
        end

        n_s2_work            = '0;
        n_s2_work.brightness = r_s1_hi;

        // grey pixel: divide 0 by 1 so the hue quotient comes out 0
        if (r_s1_spread == '0) begin
            n_s2_work.hue_rem = '0;
            n_s2_work.hue_den = HUE_DEN_W'(1);
        end else begin
            n_s2_work.hue_rem = hue_num[HUE_DEN_W-1:0];
            n_s2_work.hue_den = six_spread[HUE_DEN_W-1:0];
        end

        // min of zero gives exactly one, which clips to all ones
        n_s2_work.sat_full = (r_s1_hi != '0) && (r_s1_spread == r_s1_hi);
        n_s2_work.sat_rem  = n_s2_work.sat_full ? '0 : r_s1_spread;
        n_s2_work.sat_den  = (r_s1_hi == '0) ? CHANNEL_BITS'(1) : r_s1_hi;
    end

    assign s1_ready = !r_s1_valid || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_work <= n_s2_work;
        end
    end

    // ---------------- stages 3..6: pipelined long division ----------------
    logic      div_valid [DIV_STAGES+1];
    logic      div_ready [DIV_STAGES+1];
    t_div_work div_work  [DIV_STAGES+1];

    assign div_valid[0] = r_s2_valid;
    assign div_work[0]  = r_s2_work;
    assign s2_ready     = !r_s2_valid || div_ready[0];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        rhc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_ready (div_ready[g]),
            .i_work  (div_work[g]),
            .o_valid (div_valid[g+1]),
            .i_ready (div_ready[g+1]),
            .o_work  (div_work[g+1])
        );
    end

    // ---------------- output request ----------------
    assign div_ready[DIV_STAGES] = i_out_ready;
    assign o_out_valid           = div_valid[DIV_STAGES];

    always_comb begin
        o_out_req.hue        = div_work[DIV_STAGES].hue_q;
        o_out_req.saturation = div_work[DIV_STAGES].sat_full ? '1
                                                             : div_work[DIV_STAGES].sat_q;
        o_out_req.brightness = div_work[DIV_STAGES].brightness;
    end

endmodule

`default_nettype wire

@@ design/rhc_checker.sv @@
`default_nettype none

module rhc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input rhc_pkg::t_hsv   o_out_req
);
    import rhc_pkg::*;

    // a stalled result request stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output request dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_req))
        else $error("output payload changed while stalled");

    // black pixel has no hue and no saturation
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.brightness == '0) |->
            (o_out_req.saturation == '0) && (o_out_req.hue == '0))
        else $error("black pixel with nonzero hue or saturation");

    // zero saturation means a grey pixel, whose hue is zero
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.saturation == '0) |-> (o_out_req.hue == '0))
        else $error("grey pixel with nonzero hue");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

`default_nettype wire

@@ verif/hsv_result_checker.sv @@
`timescale 1ns / 1ps

module hsv_result_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  rhc_pkg::t_pixel i_in_req,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  rhc_pkg::t_hsv   i_out_req,
    output int              o_fail_count,
    output int              o_pending
);
    import rhc_pkg::*;

    // hue sector offsets in sixths of a turn
    localparam int RED_SECTOR   = 0;
    localparam int GREEN_SECTOR = 2;
    localparam int BLUE_SECTOR  = 4;
    localparam int TURN_SIXTHS  = 6;
    localparam int FRAC_ONE     = 1 << FRAC_BITS;
    localparam int FRAC_MAX     = FRAC_ONE - 1;

    t_hsv pending_hsv[$];
    int   fail_count = 0;

    function automatic t_hsv hsv_of_pixel(input t_pixel px);
        int   r;
        int   g;
        int   b;
        int   hi;
        int   lo;
        int   spread;
        int   num;
        int   sat;
        int   hue;
        t_hsv res;
        r  = int'(px.red);
        g  = int'(px.green);
        b  = int'(px.blue);
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        spread = hi - lo;
        sat = 0;
        if (hi > 0) begin
            sat = (spread * FRAC_ONE) / hi;
            if (sat > FRAC_MAX) sat = FRAC_MAX;
        end
        hue = 0;
        if (spread > 0) begin
            // ties go to red, then green
            if (r == hi)
                num = RED_SECTOR * spread + (g - b);
            else if (g == hi)
                num = GREEN_SECTOR * spread + (b - r);
            else
                num = BLUE_SECTOR * spread + (r - g);
            if (num < 0) num += TURN_SIXTHS * spread;
            hue = (num * FRAC_ONE) / (TURN_SIXTHS * spread);
        end
        res.hue        = FRAC_BITS'(hue);
        res.saturation = FRAC_BITS'(sat);
        res.brightness = CHANNEL_BITS'(hi);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_hsv want;
        if (!i_rst_n) begin
            pending_hsv.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                pending_hsv.push_back(hsv_of_pixel(i_in_req));
            if (i_out_valid && i_out_ready) begin
                if (pending_hsv.size() == 0) begin
                    report_mismatch("unexpected request", 1, 0);
                end else begin
                    want = pending_hsv.pop_front();
                    if (i_out_req.hue != want.hue)
                        report_mismatch("hue", i_out_req.hue, want.hue);
                    if (i_out_req.saturation != want.saturation)
                        report_mismatch("saturation", i_out_req.saturation,
                                        want.saturation);
                    if (i_out_req.brightness != want.brightness)
                        report_mismatch("brightness", i_out_req.brightness,
                                        want.brightness);
                end
            end
        end
        o_pending    <= pending_hsv.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ verif/rgb_to_hsv_converter_core_tb.sv @@
`timescale 1ns / 1ps

module rgb_to_hsv_converter_core_tb;
    import rhc_pkg::*;

    // random part of the run, and the tail of it that runs with no idling
    localparam int RANDOM_PIXELS    = 2000;
    localparam int STEADY_PIXELS    = 300;
    // items pushed while the output is held off, well past the pipe depth
    localparam int BURST_PIXELS     = 40;
    localparam int LONG_HOLD_CYCLES = 60;
    // a short drain is plenty for the pipe
    localparam int DRAIN_CYCLES     = 20;
    // bound on the slowest legal run of about 2100 items, with the longest gaps and stalls
    localparam int CYCLE_LIMIT      = 200000;
    localparam int NUM_CORNERS      = 22;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_ready;
    t_pixel i_in_req    = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_hsv   o_out_req;

    int fail_count;
    int pending_count;
    int cycle_count = 0;

    // idling controls for the sender and the receiver, set by the stimulus
    bit tx_gaps_on    = 1'b1;
    bit rx_stalls_on  = 1'b1;
    bit long_hold_req = 1'b0;

    // corner pixels packed as red, green, blue
    logic [3*CHANNEL_BITS-1:0] corner_px [NUM_CORNERS] = '{
        24'h000000,  // black: hue and saturation 0
        24'hFFFFFF,  // grey at full scale
        24'h808080,  // mid grey
        24'h010101,  // dimmest grey
        24'hFF0000,  // pure red, min 0 so saturation clips
        24'h00FF00,  // pure green
        24'h0000FF,  // pure blue
        24'hFFFF00,  // red and green tie, red sector wins
        24'h00FFFF,  // green and blue tie, green sector wins
        24'hFF00FF,  // red and blue tie, red sector wins
        24'hFF0001,  // red sector with a negative numerator, wraps to last sixth
        24'h80007F,  // same again at mid scale
        24'h010000,  // smallest non-zero max
        24'hFFFEFE,  // spread of one at the top
        24'hFEFFFF,  // spread of one, red is the odd one out
        24'h55AA55,  // alternating bits
        24'hAA55AA,
        24'h010100,
        24'hC86432,  // channel orderings across the red, green and blue sectors
        24'h3264C8,
        24'h6432C8,
        24'h32C864
    };

    rgb_to_hsv_converter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_req  (o_out_req)
    );

    hsv_result_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_req   (o_out_req),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one pixel and hold it until the block takes it; valid stays high
    // afterwards unless a random gap is taken, so back-to-back requests never
    // drop valid within a step
    task automatic send_pixel(input t_pixel px);
        i_in_valid <= 1'b1;
        i_in_req   <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // lower valid and wait for every predicted pixel to come back
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // half uniform pixels, with a share of greys, ties, clipped channels and
    // near-black values so the odd branches of the hue math get hit often
    function automatic t_pixel random_pixel();
        t_pixel px;
        int     base;
        px.red   = CHANNEL_BITS'($urandom);
        px.green = CHANNEL_BITS'($urandom);
        px.blue  = CHANNEL_BITS'($urandom);
        case ($urandom_range(0, 9))
            5: begin
                // grey or nearly grey
                base     = $urandom_range(0, 253);
                px.red   = CHANNEL_BITS'(base + $urandom_range(0, 2));
                px.green = CHANNEL_BITS'(base + $urandom_range(0, 2));
                px.blue  = CHANNEL_BITS'(base + $urandom_range(0, 2));
            end
            6: begin
                // two channels tied, often at the max
                case ($urandom_range(0, 2))
                    0:       px.green = px.red;
                    1:       px.blue  = px.green;
                    default: px.blue  = px.red;
                endcase
            end
            7: begin
                // one channel at zero, saturation clips
                case ($urandom_range(0, 2))
                    0:       px.red   = '0;
                    1:       px.green = '0;
                    default: px.blue  = '0;
                endcase
            end
            8: begin
                // tiny spreads and maxima
                px.red   = CHANNEL_BITS'($urandom_range(0, 3));
                px.green = CHANNEL_BITS'($urandom_range(0, 3));
                px.blue  = CHANNEL_BITS'($urandom_range(0, 3));
            end
            9: begin
                // channels at the rails
                px.red   = $urandom_range(0, 1) ? '1 : '0;
                px.green = $urandom_range(0, 1) ? '1 : '0;
                px.blue  = $urandom_range(0, 1) ? '1 : '0;
            end
            default: ;
        endcase
        return px;
    endfunction

    // output side: random stall bursts, plus one long hold on request
    initial begin : result_sink
        int burst;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 7);
                i_out_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int i;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners with idling on both sides
        for (i = 0; i < NUM_CORNERS; i++)
            send_pixel(t_pixel'(corner_px[i]));

        // back pressure: hold the output while requests keep coming so the pipe
        // fills and the input stalls
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        for (i = 0; i < BURST_PIXELS; i++)
            send_pixel(random_pixel());

        // sender pause until the pipe is empty
        drain_pipe();
        tx_gaps_on = 1'b1;

        // random pixels, idling on both sides until the steady tail
        for (i = 0; i < RANDOM_PIXELS; i++) begin
            if (i == RANDOM_PIXELS - STEADY_PIXELS) begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            send_pixel(random_pixel());
        end

        drain_pipe();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
